/* sv/tbs_pkg.sv */
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants for the barycentric setup block
// Coordinate, vector and queue word types, axis codes and datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tbs_pkg;

   // coordinate and difference widths
   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int MAG_W   = PROD_W + 1;
   localparam int WIDE_W  = 2 * MAG_W;

   // axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0]           vec_type;
   typedef vec_type [2:0]             tri_type;

   // classified triangle: axis plus projected u/v of a, b, c
   typedef struct packed {
      logic [1:0]    axis;
      coord_type [2:0] pu;
      coord_type [2:0] pv;
   } item_type;

   // one setup result
   typedef struct packed {
      logic [1:0] axis;
      coord_type  r0u;
      coord_type  r0v;
      coord_type  r0o;
      coord_type  r1u;
      coord_type  r1v;
      coord_type  r1o;
      logic       degenerate;
   } result_type;

endpackage

`default_nettype wire

/* sv/tbs_front.sv */
// ----------------------------------------------------------------------------
// tbs_front: normal and major-axis classification
// Three-stage pipeline: edge differences, cross products, normal magnitudes;
// then picks the major axis and projects the vertices into a queue word.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_front import tbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_push,
   output logic     in_full,
   input  tri_type  in_tri,
   output logic     q_push,
   output item_type q_item,
   input  logic     q_full
);

   logic adv;

   logic                     s1_v_ff, s2_v_ff, s3_v_ff;
   tri_type                  s1_tri_ff, s2_tri_ff, s3_tri_ff;
   logic signed [DIFF_W-1:0] ab_ff [3];
   logic signed [DIFF_W-1:0] cb_ff [3];
   logic signed [PROD_W-1:0] pr_ff [6];
   logic [MAG_W-1:0]         nrm_ff [3];

   logic signed [MAG_W-1:0]  nd [3];
   logic [1:0]               ax_a, ax;
   logic [MAG_W-1:0]         nsel;
   logic [1:0]               uidx, vidx;

   // pipeline moves when the last stage is empty or drains
   assign adv     = !s3_v_ff || !q_full;
   assign in_full = !adv;
   assign q_push  = s3_v_ff && !q_full;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= in_push;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // signed normal components
   always_comb begin
      nd[0] = MAG_W'(pr_ff[0]) - MAG_W'(pr_ff[1]);
      nd[1] = MAG_W'(pr_ff[2]) - MAG_W'(pr_ff[3]);
      nd[2] = MAG_W'(pr_ff[4]) - MAG_W'(pr_ff[5]);
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tri_ff <= in_tri;
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= DIFF_W'($signed(in_tri[0][i])) - DIFF_W'($signed(in_tri[1][i]));
            cb_ff[i] <= DIFF_W'($signed(in_tri[2][i])) - DIFF_W'($signed(in_tri[1][i]));
         end
         s2_tri_ff <= s1_tri_ff;
         pr_ff[0]  <= PROD_W'(ab_ff[1]) * PROD_W'(cb_ff[2]);
         pr_ff[1]  <= PROD_W'(ab_ff[2]) * PROD_W'(cb_ff[1]);
         pr_ff[2]  <= PROD_W'(ab_ff[2]) * PROD_W'(cb_ff[0]);
         pr_ff[3]  <= PROD_W'(ab_ff[0]) * PROD_W'(cb_ff[2]);
         pr_ff[4]  <= PROD_W'(ab_ff[0]) * PROD_W'(cb_ff[1]);
         pr_ff[5]  <= PROD_W'(ab_ff[1]) * PROD_W'(cb_ff[0]);
         s3_tri_ff <= s2_tri_ff;
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i] <= nd[i][MAG_W-1] ? MAG_W'(-nd[i]) : MAG_W'(nd[i]);
         end
      end
   end

   // major axis, ties to the later axis
   always_comb begin
      ax_a = (nrm_ff[1] < nrm_ff[0]) ? AXIS_X : AXIS_Y;
      nsel = (ax_a == AXIS_X) ? nrm_ff[0] : nrm_ff[1];
      ax   = (nrm_ff[2] < nsel) ? ax_a : AXIS_Z;
      case (ax)
         AXIS_X: begin
            uidx = AXIS_Y;
            vidx = AXIS_Z;
         end
         AXIS_Y: begin
            uidx = AXIS_Z;
            vidx = AXIS_X;
         end
         default: begin
            uidx = AXIS_X;
            vidx = AXIS_Y;
         end
      endcase
   end

   // projected queue word
   always_comb begin
      q_item.axis = ax;
      for (int i = 0; i < 3; i++) begin
         q_item.pu[i] = s3_tri_ff[i][uidx];
         q_item.pv[i] = s3_tri_ff[i][vidx];
      end
   end

endmodule

`default_nettype wire

/* sv/tbs_queue.sv */
// ----------------------------------------------------------------------------
// tbs_queue: short word queue between front and back
// Four-entry circular buffer with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_queue import tbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   item_type      mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic          do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_item;
   end

endmodule

`default_nettype wire

/* sv/tbs_back.sv */
// ----------------------------------------------------------------------------
// tbs_back: per-rotation row setup sequencer
// Shared 33x33 multiplier, two bit-serial wide multipliers for the height
// test, and a restoring divider for the six rounded, saturated row fields.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_back import tbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  item_type     q_item,
   output logic         q_pop,
   input  logic [31:0]  thr,
   output logic         out_empty,
   input  logic         out_pop,
   output result_type   out_word
);

   localparam int NW = 70 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);
   localparam int SW = $clog2(MAG_W + 1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_DIFF   = 11'b00000000010,
      ST_MUL    = 11'b00000000100,
      ST_SUM    = 11'b00000001000,
      ST_DCHK   = 11'b00000010000,
      ST_SER    = 11'b00000100000,
      ST_KCHK   = 11'b00001000000,
      ST_DLOAD  = 11'b00010000000,
      ST_DIV    = 11'b00100000000,
      ST_DSTORE = 11'b01000000000,
      ST_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff;
   logic      load_out;

   item_type                 item_ff;
   logic                     rot_ff;
   logic                     deg_ff;
   coord_type                rows_ff [2][3];
   logic signed [DIFF_W-1:0] e0_ff, e1_ff, f0_ff, f1_ff;
   coord_type                p2u_ff, p2v_ff;
   logic [2:0]               step_ff;
   logic signed [PROD_W-1:0] pr_ff [6];
   logic [PROD_W-1:0]        d1_ff;
   logic [MAG_W-1:0]         kmag_ff;
   logic                     kneg_ff;
   logic signed [MAG_W-1:0]  off_ff;

   logic [WIDE_W-1:0] sq_acc_ff, sq_mc_ff, td_acc_ff, td_mc_ff;
   logic [MAG_W-1:0]  sq_mp_ff, td_mp_ff;
   logic [SW-1:0]     ser_cnt_ff;

   logic [1:0]        sel_ff;
   logic [NW-1:0]     dn_ff, dq_ff;
   logic [MAG_W+1:0]  dr_ff;
   logic              dneg_ff;
   logic [CW-1:0]     dcnt_ff;

   logic [1:0]               i1, i2, i3;
   logic signed [DIFF_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] prod;
   logic signed [MAG_W-1:0]  kval;
   logic [DIFF_W-1:0]        e0mag, e1mag;
   logic [MAG_W-1:0]         offmag;
   logic [MAG_W:0]           dden;
   logic [MAG_W+1:0]         rs;
   logic                     d1_small, k_small;
   coord_type                sat;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign load_out  = (state_ff == ST_DONE) && (!out_valid_ff || out_pop);
   assign out_empty = !out_valid_ff;
   assign d1_small  = (d1_ff <= PROD_W'(thr));
   assign k_small   = (sq_acc_ff <= td_acc_ff);

   // rotation vertex indexes
   assign i1 = rot_ff ? 2'd1 : 2'd0;
   assign i2 = rot_ff ? 2'd2 : 2'd1;
   assign i3 = rot_ff ? 2'd0 : 2'd2;

   // shared multiplier operands
   always_comb begin
      case (step_ff)
         3'd0: begin
            opa = e0_ff;
            opb = e0_ff;
         end
         3'd1: begin
            opa = e1_ff;
            opb = e1_ff;
         end
         3'd2: begin
            opa = e0_ff;
            opb = f1_ff;
         end
         3'd3: begin
            opa = e1_ff;
            opb = f0_ff;
         end
         3'd4: begin
            opa = DIFF_W'(p2u_ff);
            opb = e1_ff;
         end
         default: begin
            opa = DIFF_W'(p2v_ff);
            opb = e0_ff;
         end
      endcase
      prod = PROD_W'(opa) * PROD_W'(opb);
   end

   // magnitudes, divisor and restoring step
   always_comb begin
      kval   = MAG_W'(pr_ff[2]) - MAG_W'(pr_ff[3]);
      e0mag  = e0_ff[DIFF_W-1] ? DIFF_W'(-e0_ff) : DIFF_W'(e0_ff);
      e1mag  = e1_ff[DIFF_W-1] ? DIFF_W'(-e1_ff) : DIFF_W'(e1_ff);
      offmag = off_ff[MAG_W-1] ? MAG_W'(-off_ff) : MAG_W'(off_ff);
      dden   = {kmag_ff, 1'b0};
      rs     = {dr_ff[MAG_W:0], dn_ff[NW-1]};
   end

   // round-half-away quotient saturated to 32 bits
   always_comb begin
      if (!dneg_ff) begin
         sat = (dq_ff[NW-1:31] != '0) ? 32'sh7FFFFFFF : coord_type'(dq_ff[31:0]);
      end else if ((dq_ff[NW-1:32] != '0) || (dq_ff[31] && (dq_ff[30:0] != '0))) begin
         sat = 32'sh80000000;
      end else begin
         sat = coord_type'(-dq_ff[31:0]);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (!q_empty) state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_MUL;
         ST_MUL:    if (step_ff == 3'd5) state_in = ST_SUM;
         ST_SUM:    state_in = ST_DCHK;
         ST_DCHK:   state_in = d1_small ? ST_DONE : ST_SER;
         ST_SER:    if (ser_cnt_ff == SW'(MAG_W - 1)) state_in = ST_KCHK;
         ST_KCHK:   state_in = k_small ? ST_DONE : ST_DLOAD;
         ST_DLOAD:  state_in = ST_DIV;
         ST_DIV:    if (dcnt_ff == CW'(NW - 1)) state_in = ST_DSTORE;
         ST_DSTORE: begin
            if (sel_ff != 2'd2) state_in = ST_DLOAD;
            else if (rot_ff)    state_in = ST_DONE;
            else                state_in = ST_DIFF;
         end
         ST_DONE:   if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out)     out_valid_ff <= 1'b1;
         else if (out_pop) out_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_ff <= q_item;
               rot_ff  <= 1'b0;
               deg_ff  <= 1'b0;
               for (int j = 0; j < 2; j++)
                  for (int i = 0; i < 3; i++) rows_ff[j][i] <= '0;
            end
         end
         ST_DIFF: begin
            e0_ff   <= DIFF_W'(item_ff.pu[i3]) - DIFF_W'(item_ff.pu[i2]);
            e1_ff   <= DIFF_W'(item_ff.pv[i3]) - DIFF_W'(item_ff.pv[i2]);
            f0_ff   <= DIFF_W'(item_ff.pu[i1]) - DIFF_W'(item_ff.pu[i2]);
            f1_ff   <= DIFF_W'(item_ff.pv[i1]) - DIFF_W'(item_ff.pv[i2]);
            p2u_ff  <= item_ff.pu[i2];
            p2v_ff  <= item_ff.pv[i2];
            step_ff <= 3'd0;
         end
         ST_MUL: begin
            pr_ff[step_ff] <= prod;
            step_ff        <= step_ff + 3'd1;
         end
         ST_SUM: begin
            d1_ff   <= PROD_W'($unsigned(pr_ff[0])) + PROD_W'($unsigned(pr_ff[1]));
            kmag_ff <= kval[MAG_W-1] ? MAG_W'(-kval) : MAG_W'(kval);
            kneg_ff <= kval[MAG_W-1];
            off_ff  <= MAG_W'(pr_ff[4]) - MAG_W'(pr_ff[5]);
         end
         ST_DCHK: begin
            if (d1_small) begin
               deg_ff <= 1'b1;
               for (int j = 0; j < 2; j++)
                  for (int i = 0; i < 3; i++) rows_ff[j][i] <= '0;
            end
            sq_acc_ff  <= '0;
            sq_mc_ff   <= WIDE_W'(kmag_ff);
            sq_mp_ff   <= kmag_ff;
            td_acc_ff  <= '0;
            td_mc_ff   <= WIDE_W'(d1_ff);
            td_mp_ff   <= MAG_W'(thr);
            ser_cnt_ff <= '0;
         end
         ST_SER: begin
            if (sq_mp_ff[0]) sq_acc_ff <= sq_acc_ff + sq_mc_ff;
            if (td_mp_ff[0]) td_acc_ff <= td_acc_ff + td_mc_ff;
            sq_mc_ff   <= sq_mc_ff << 1;
            td_mc_ff   <= td_mc_ff << 1;
            sq_mp_ff   <= sq_mp_ff >> 1;
            td_mp_ff   <= td_mp_ff >> 1;
            ser_cnt_ff <= ser_cnt_ff + 1'b1;
         end
         ST_KCHK: begin
            if (k_small) begin
               deg_ff <= 1'b1;
               for (int j = 0; j < 2; j++)
                  for (int i = 0; i < 3; i++) rows_ff[j][i] <= '0;
            end
            sel_ff <= 2'd0;
         end
         ST_DLOAD: begin
            // numerator scaled, doubled and biased by |k| for rounding
            case (sel_ff)
               2'd0: begin
                  dn_ff   <= (NW'(e1mag) << (2 * FRAC_BITS + 1)) + NW'(kmag_ff);
                  dneg_ff <= (!e1_ff[DIFF_W-1] && (e1_ff != '0)) ^ kneg_ff;
               end
               2'd1: begin
                  dn_ff   <= (NW'(e0mag) << (2 * FRAC_BITS + 1)) + NW'(kmag_ff);
                  dneg_ff <= e0_ff[DIFF_W-1] ^ kneg_ff;
               end
               default: begin
                  dn_ff   <= (NW'(offmag) << (FRAC_BITS + 1)) + NW'(kmag_ff);
                  dneg_ff <= off_ff[MAG_W-1] ^ kneg_ff;
               end
            endcase
            dr_ff   <= '0;
            dq_ff   <= '0;
            dcnt_ff <= '0;
         end
         ST_DIV: begin
            dn_ff   <= dn_ff << 1;
            dcnt_ff <= dcnt_ff + 1'b1;
            if (rs >= (MAG_W+2)'(dden)) begin
               dr_ff <= rs - (MAG_W+2)'(dden);
               dq_ff <= {dq_ff[NW-2:0], 1'b1};
            end else begin
               dr_ff <= rs;
               dq_ff <= {dq_ff[NW-2:0], 1'b0};
            end
         end
         ST_DSTORE: begin
            rows_ff[rot_ff][sel_ff] <= sat;
            sel_ff <= sel_ff + 2'd1;
            if (sel_ff == 2'd2) rot_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   // result word register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_word.axis       <= item_ff.axis;
         out_word.r0u        <= rows_ff[0][0];
         out_word.r0v        <= rows_ff[0][1];
         out_word.r0o        <= rows_ff[0][2];
         out_word.r1u        <= rows_ff[1][0];
         out_word.r1v        <= rows_ff[1][1];
         out_word.r1o        <= rows_ff[1][2];
         out_word.degenerate <= deg_ff;
      end
   end

endmodule

`default_nettype wire

/* sv/triangle_barycentric_setup_top.sv */
// ----------------------------------------------------------------------------
// triangle_barycentric_setup_top: barycentric transform setup for triangles
// Major-axis projection and 2x3 barycentric rows in signed fixed point.
// ----------------------------------------------------------------------------
// A triangle word is taken on push while full is low; the front pipeline
// (three stages) finds the major normal axis and hands the projected
// triangle to a four-entry queue, so new triangles keep entering while the
// back end works, until the front pipeline and the queue hold seven words.
// The back end sequences each word through two rotations: a differences
// state, six products on a shared multiplier, a sum state and an edge-test
// state, bit-serial multiplication and a compare state for the height test,
// then three restoring divisions of 70+FRAC_BITS quotient bits, each with a
// load and a store state. Each word also passes an idle and a done state; a
// triangle takes less time in the back end when it is found degenerate
// early, more while the output register waits on pop. The back end takes the
// next word only after the current result is loaded into the output register;
// that sequence sets the sustained rate. Results are held in an output
// register and read with pop.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric_setup_top import tbs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic signed [31:0] req_a_x,
   input  logic signed [31:0] req_a_y,
   input  logic signed [31:0] req_a_z,
   input  logic signed [31:0] req_b_x,
   input  logic signed [31:0] req_b_y,
   input  logic signed [31:0] req_b_z,
   input  logic signed [31:0] req_c_x,
   input  logic signed [31:0] req_c_y,
   input  logic signed [31:0] req_c_z,
   output logic              empty,
   input  logic              pop,
   output logic [1:0]        rsp_major_axis,
   output logic signed [31:0] rsp_row0_u,
   output logic signed [31:0] rsp_row0_v,
   output logic signed [31:0] rsp_row0_offset,
   output logic signed [31:0] rsp_row1_u,
   output logic signed [31:0] rsp_row1_v,
   output logic signed [31:0] rsp_row1_offset,
   output logic              rsp_degenerate,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   logic [31:0] thr_ff;
   tri_type     in_tri;
   item_type    f_item, q_item;
   logic        f_push, q_full, q_pop, q_empty;
   result_type  res;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset)          thr_ff <= 32'd1;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   // input word packing
   always_comb begin
      in_tri[0] = {req_a_z, req_a_y, req_a_x};
      in_tri[1] = {req_b_z, req_b_y, req_b_x};
      in_tri[2] = {req_c_z, req_c_y, req_c_x};
   end

   tbs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_push (push),
      .in_full (full),
      .in_tri  (in_tri),
      .q_push  (f_push),
      .q_item  (f_item),
      .q_full  (q_full)
   );

   tbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   tbs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .thr       (thr_ff),
      .out_empty (empty),
      .out_pop   (pop),
      .out_word  (res)
   );

   // result word unpacking
   assign rsp_major_axis  = res.axis;
   assign rsp_row0_u      = res.r0u;
   assign rsp_row0_v      = res.r0v;
   assign rsp_row0_offset = res.r0o;
   assign rsp_row1_u      = res.r1u;
   assign rsp_row1_v      = res.r1v;
   assign rsp_row1_offset = res.r1o;
   assign rsp_degenerate  = res.degenerate;

endmodule

`default_nettype wire
